// ===== design/first_fit_segment_allocator_macros.svh =====
// assertion macros for the first-fit segment allocator
// used by the top level only, no other dependencies
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FFSA_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffsa check failed");

// next-cycle implication, sampled on clk, off during reset
`define FFSA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffsa check failed");

`endif

// ===== design/ffsa_pkg.sv =====
// shared types and constants of the first-fit segment allocator
// no dependencies
package ffsa_pkg;

    localparam int MEMORY_BYTES = 65536;
    localparam int MAX_SEGMENTS = 64;
    localparam int OFF_W        = 16;
    localparam int LEN_W        = 17;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    localparam logic [LEN_W-1:0] MEM_LEN = LEN_W'(MEMORY_BYTES);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_DOUBLE   = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_FULL     = 3'd6
    } ffsa_status_t;

    typedef enum logic [1:0] {
        CL_RUN,
        CL_ZERO,
        CL_RANGE,
        CL_NOSPACE
    } ffsa_class_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } ffsa_cmd_t;

    typedef struct packed {
        ffsa_cmd_t         cmd;
        logic [LEN_W-1:0]  size;
        logic [OFF_W-1:0]  offset;
        ffsa_class_t       cls;
    } ffsa_item_t;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             free;
    } ffsa_seg_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OPEN_RD,
        S_OPEN_WR,
        S_SPLIT_WR,
        S_SPLIT_WR2,
        S_FN_RD,
        S_FN_CHK,
        S_FP_RD,
        S_FP_CHK,
        S_RM_RD,
        S_RM_WR,
        S_DONE
    } ffsa_state_t;

endpackage

// ===== design/ffsa_front.sv =====
// front part: accepts command words, classifies them, two-entry queue
// depends on ffsa_pkg
module ffsa_front
    import ffsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic              command,
    input  logic [LEN_W-1:0]  request_size,
    input  logic [OFF_W-1:0]  block_offset,
    output logic              q_valid,
    output ffsa_item_t        q_item,
    input  logic              q_pop
);

    ffsa_item_t  q_mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  q_cnt_reg, q_cnt_next;
    ffsa_item_t  new_item;
    logic        push;
    logic        pop;

    // early classification of cases that need no table walk
    always_comb
    begin
        new_item.cmd    = ffsa_cmd_t'(command);
        new_item.size   = request_size;
        new_item.offset = block_offset;
        new_item.cls    = CL_RUN;
        if (new_item.cmd == CMD_ALLOC)
        begin
            if (request_size == '0)
                new_item.cls = CL_ZERO;
            else if (request_size > MEM_LEN)
                new_item.cls = CL_NOSPACE;
        end
        else if ({1'b0, block_offset} >= MEM_LEN)
        begin
            new_item.cls = CL_RANGE;
        end
    end

    assign cmd_stall = (q_cnt_reg == 2'd2);
    assign push      = cmd_valid && !cmd_stall;
    assign pop       = q_pop && q_valid;
    assign q_valid   = (q_cnt_reg != 2'd0);
    assign q_item    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= new_item;
    end

endmodule

// ===== design/ffsa_back.sv =====
// back part: segment table memory, search and shift sequencer, result register
// depends on ffsa_pkg
module ffsa_back
    import ffsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  ffsa_item_t        q_item,
    output logic              q_pop,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [2:0]        status,
    output logic [OFF_W-1:0]  alloc_offset,
    output logic [CNT_W-1:0]  seg_count
);

    ffsa_seg_t    seg_mem [MAX_SEGMENTS];
    ffsa_seg_t    rd_data_reg;

    ffsa_state_t  state_reg, state_next;
    ffsa_item_t   item_reg, item_next;
    ffsa_seg_t    cur_reg, cur_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic         last_rm_reg, last_rm_next;
    ffsa_status_t res_st_reg, res_st_next;
    logic [OFF_W-1:0] res_off_reg, res_off_next;
    logic         out_valid_reg;
    ffsa_status_t out_st_reg;
    logic [OFF_W-1:0] out_off_reg;

    logic         mem_we;
    logic [IDX_W-1:0] mem_wa, mem_ra;
    ffsa_seg_t    mem_wd;
    logic         out_load;
    logic         fits, exact, hit;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !res_stall);
    assign fits  = rd_data_reg.free && (rd_data_reg.len >= item_reg.size);
    assign exact = (rd_data_reg.len == item_reg.size);
    assign hit   = ({1'b0, rd_data_reg.start} == {1'b0, item_reg.offset});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
                state_next = S_IDLE;
            S_IDLE:
                if (q_valid)
                    state_next = (q_item.cls == CL_RUN) ? S_SCAN_RD : S_DONE;
            S_SCAN_RD:
                state_next = (idx_reg == cnt_reg) ? S_DONE : S_SCAN_CHK;
            S_SCAN_CHK:
                if (item_reg.cmd == CMD_ALLOC)
                begin
                    if (!fits)
                        state_next = S_SCAN_RD;
                    else if (exact || cnt_reg == MAX_CNT)
                        state_next = S_DONE;
                    else
                        state_next = S_OPEN_RD;
                end
                else if (!hit)
                    state_next = S_SCAN_RD;
                else
                    state_next = rd_data_reg.free ? S_DONE : S_FN_RD;
            S_OPEN_RD:
                state_next = (k_reg == idx_reg + 1'b1) ? S_SPLIT_WR : S_OPEN_WR;
            S_OPEN_WR:
                state_next = S_OPEN_RD;
            S_SPLIT_WR:
                state_next = S_SPLIT_WR2;
            S_SPLIT_WR2:
                state_next = S_DONE;
            S_FN_RD:
                state_next = (idx_reg + 1'b1 < cnt_reg) ? S_FN_CHK : S_FP_RD;
            S_FN_CHK:
                state_next = rd_data_reg.free ? S_RM_RD : S_FP_RD;
            S_FP_RD:
                state_next = (idx_reg != '0) ? S_FP_CHK : S_DONE;
            S_FP_CHK:
                state_next = rd_data_reg.free ? S_RM_RD : S_DONE;
            S_RM_RD:
                if (k_reg + 1'b1 < cnt_reg)
                    state_next = S_RM_WR;
                else
                    state_next = last_rm_reg ? S_DONE : S_FP_RD;
            S_RM_WR:
                state_next = S_RM_RD;
            S_DONE:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        item_next    = item_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        last_rm_next = last_rm_reg;
        res_st_next  = res_st_reg;
        res_off_next = res_off_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = idx_reg[IDX_W-1:0];
        mem_wd       = cur_reg;
        mem_ra       = idx_reg[IDX_W-1:0];
        case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                mem_wa = '0;
                mem_wd = '{start: '0, len: MEM_LEN, free: 1'b1};
            end
            S_IDLE:
            begin
                q_pop        = q_valid;
                item_next    = q_item;
                idx_next     = '0;
                res_off_next = '0;
                case (q_item.cls)
                    CL_ZERO:    res_st_next = ST_ZERO;
                    CL_RANGE:   res_st_next = ST_RANGE;
                    CL_NOSPACE: res_st_next = ST_NOSPACE;
                    default:    res_st_next = ST_OK;
                endcase
            end
            S_SCAN_RD:
            begin
                if (idx_reg == cnt_reg)
                    res_st_next = (item_reg.cmd == CMD_ALLOC) ? ST_NOSPACE : ST_NOTFOUND;
            end
            S_SCAN_CHK:
            begin
                if (item_reg.cmd == CMD_ALLOC)
                begin
                    if (!fits)
                        idx_next = idx_reg + 1'b1;
                    else if (exact)
                    begin
                        mem_we       = 1'b1;
                        mem_wd       = '{start: rd_data_reg.start, len: item_reg.size,
                                         free: 1'b0};
                        res_off_next = rd_data_reg.start;
                    end
                    else if (cnt_reg == MAX_CNT)
                        res_st_next = ST_FULL;
                    else
                    begin
                        cur_next = rd_data_reg;
                        k_next   = cnt_reg;
                    end
                end
                else if (!hit)
                    idx_next = idx_reg + 1'b1;
                else if (rd_data_reg.free)
                    res_st_next = ST_DOUBLE;
                else
                    cur_next = '{start: rd_data_reg.start, len: rd_data_reg.len,
                                 free: 1'b1};
            end
            S_OPEN_RD:
            begin
                mem_ra = IDX_W'(k_reg - 1'b1);
            end
            S_OPEN_WR:
            begin
                mem_we = 1'b1;
                mem_wa = k_reg[IDX_W-1:0];
                mem_wd = rd_data_reg;
                k_next = k_reg - 1'b1;
            end
            S_SPLIT_WR:
            begin
                // remainder goes right after the granted segment
                mem_we = 1'b1;
                mem_wa = IDX_W'(idx_reg + 1'b1);
                mem_wd = '{start: OFF_W'(cur_reg.start + item_reg.size[OFF_W-1:0]),
                           len: cur_reg.len - item_reg.size, free: 1'b1};
            end
            S_SPLIT_WR2:
            begin
                mem_we       = 1'b1;
                mem_wd       = '{start: cur_reg.start, len: item_reg.size, free: 1'b0};
                cnt_next     = cnt_reg + 1'b1;
                res_off_next = cur_reg.start;
            end
            S_FN_RD:
            begin
                mem_ra = IDX_W'(idx_reg + 1'b1);
                if (!(idx_reg + 1'b1 < cnt_reg))
                    mem_we = 1'b1;
            end
            S_FN_CHK:
            begin
                mem_we = 1'b1;
                if (rd_data_reg.free)
                begin
                    mem_wd       = '{start: cur_reg.start,
                                     len: cur_reg.len + rd_data_reg.len, free: 1'b1};
                    cur_next     = mem_wd;
                    k_next       = idx_reg + 1'b1;
                    last_rm_next = 1'b0;
                end
            end
            S_FP_RD:
            begin
                mem_ra = IDX_W'(idx_reg - 1'b1);
            end
            S_FP_CHK:
            begin
                if (rd_data_reg.free)
                begin
                    mem_we       = 1'b1;
                    mem_wa       = IDX_W'(idx_reg - 1'b1);
                    mem_wd       = '{start: rd_data_reg.start,
                                     len: rd_data_reg.len + cur_reg.len, free: 1'b1};
                    k_next       = idx_reg;
                    last_rm_next = 1'b1;
                end
            end
            S_RM_RD:
            begin
                mem_ra = IDX_W'(k_reg + 1'b1);
                if (!(k_reg + 1'b1 < cnt_reg))
                    cnt_next = cnt_reg - 1'b1;
            end
            S_RM_WR:
            begin
                mem_we = 1'b1;
                mem_wa = k_reg[IDX_W-1:0];
                mem_wd = rd_data_reg;
                k_next = k_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            seg_mem[mem_wa] <= mem_wd;
        rd_data_reg <= seg_mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!res_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        last_rm_reg <= last_rm_next;
        res_st_reg  <= res_st_next;
        res_off_reg <= res_off_next;
        if (out_load)
        begin
            out_st_reg  <= res_st_reg;
            out_off_reg <= (res_st_reg == ST_OK) ? res_off_reg : '0;
        end
    end

    assign res_valid    = out_valid_reg;
    assign status       = out_st_reg;
    assign alloc_offset = out_off_reg;
    assign seg_count    = cnt_reg;

endmodule

// ===== design/first_fit_segment_allocator.sv =====
// top level of the first-fit segment allocator with coalescing
// depends on ffsa_pkg, ffsa_front, ffsa_back and the assertion macros
//
//  channel  | handshake            | word
//  ---------+----------------------+-----------------------------------------
//  cmd      | cmd_valid/cmd_stall  | command, request_size, block_offset
//  res      | res_valid/res_stall  | status, alloc_offset
//
// work: a word walks the table entries in the first-fit or offset search,
//   and moves entries when a split opens or a merge closes a slot
// rejected words (zero size, too large, out of range) skip the table walk
// reset: the init state writes table entry 0, then words flow
// stalls: the front queues two words while the back works; res_stall holds
//   the result register and the back waits before loading the next result
`include "first_fit_segment_allocator_macros.svh"
module first_fit_segment_allocator
    import ffsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic              command,
    input  logic [LEN_W-1:0]  request_size,
    input  logic [OFF_W-1:0]  block_offset,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [2:0]        status,
    output logic [OFF_W-1:0]  alloc_offset
);

    // queue between front and back
    logic        q_valid;
    logic        q_pop;
    ffsa_item_t  q_item;
    // live segment count, watched by the checks below
    logic [CNT_W-1:0] seg_count;

    ffsa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .request_size (request_size),
        .block_offset (block_offset),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    ffsa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .status       (status),
        .alloc_offset (alloc_offset),
        .seg_count    (seg_count)
    );

    // table never empties and never outgrows its storage
    `FFSA_ASSERT_NOW(a_count_range, 1'b1, (seg_count != '0) && (seg_count <= MAX_CNT))
    // a failed result carries no offset
    `FFSA_ASSERT_NOW(a_offset_zero, res_valid && (status != ST_OK), alloc_offset == '0)
    // the back only pops a word that the queue holds
    `FFSA_ASSERT_NOW(a_pop_valid, q_pop, q_valid)

endmodule
